/* rtl/ept_pkg.sv */
// Package for the page transfer sequencer: field widths, codes and the microcode table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package ept_pkg;

    // Field widths of the channels
    localparam int OP_W      = 2;
    localparam int POS_IN_W  = 19;
    localparam int COUNT_W   = 20;
    localparam int SECTOR_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int BUS_W     = 7;
    localparam int IADDR_W   = 16;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Configuration register widths
    localparam int MS_W      = 8;
    localparam int PERIOD_W  = 16;
    localparam int IAB_W     = 2;
    localparam int WAIT_W    = 24;
    localparam int WAIT_US_W = 18;   // 255 ms * 1000 < 2^18
    localparam int POS_EXT_W = 24;   // widest position, for the address split

    localparam logic [BUS_W-1:0]    DEV_ADDR_RST = 7'd80;
    localparam logic [IAB_W-1:0]    IAB_RST      = 2'd2;
    localparam logic [IAB_W-1:0]    IAB_ONE      = 2'd1;
    localparam logic [MS_W-1:0]     MS_RST       = 8'd5;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd1000;
    localparam logic [WAIT_US_W-1:0] US_PER_MS   = 18'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_ACK   = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE   = 3'd0,
        ST_CHUNK  = 3'd1,
        ST_DONE   = 3'd2,
        ST_FAILED = 3'd3,
        ST_REJECT = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEV_ADDR = 3'd0,
        CFG_IAB      = 3'd1,
        CFG_DELAY_MS = 3'd2,
        CFG_TICK_US  = 3'd3,
        CFG_SPACED   = 3'd4
    } t_cfg_idx;

    // Datapath actions of one microcode step
    typedef enum logic [3:0] {
        A_NOP,
        A_LOAD_START,
        A_DEC_WAIT,
        A_CLR_AWAIT,
        A_ADVANCE,
        A_TDIV_INIT,
        A_DIV_STEP,
        A_SET_WAIT,
        A_GO_IDLE,
        A_MDIV_INIT,
        A_CLEN,
        A_ISSUE
    } t_act;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OP_START,
        C_OP_TICK,
        C_OP_ACK,
        C_START_BAD,
        C_TICK_IGNORE,
        C_WAIT_GT1,
        C_ACK_IGNORE,
        C_ACK_FAIL,
        C_REM_ZERO,
        C_UNSPACED,
        C_DIV_MORE
    } t_cond;

    typedef logic [4:0] t_upc;

    typedef struct packed {
        t_act    act;
        logic    emit;
        t_status status;
        t_cond   cond;
        t_upc    target;
    } t_uword;

    // Microcode addresses
    localparam t_upc UA_FETCH   = 5'd0;
    localparam t_upc UA_DISP_S  = 5'd1;
    localparam t_upc UA_DISP_T  = 5'd2;
    localparam t_upc UA_DISP_A  = 5'd3;
    localparam t_upc UA_NOTHING = 5'd4;
    localparam t_upc UA_START   = 5'd5;
    localparam t_upc UA_LOAD    = 5'd6;
    localparam t_upc UA_REJECT  = 5'd7;
    localparam t_upc UA_TICK    = 5'd8;
    localparam t_upc UA_TICK_W  = 5'd9;
    localparam t_upc UA_TICK_GO = 5'd10;
    localparam t_upc UA_TICK_DEC = 5'd11;
    localparam t_upc UA_ACK     = 5'd12;
    localparam t_upc UA_ACK_CHK = 5'd13;
    localparam t_upc UA_ADVANCE = 5'd14;
    localparam t_upc UA_REM_CHK = 5'd15;
    localparam t_upc UA_SPC_CHK = 5'd16;
    localparam t_upc UA_TDIV    = 5'd17;
    localparam t_upc UA_TDIV_LP = 5'd18;
    localparam t_upc UA_SET_W   = 5'd19;
    localparam t_upc UA_FAIL    = 5'd20;
    localparam t_upc UA_DONE    = 5'd21;
    localparam t_upc UA_ISSUE   = 5'd22;
    localparam t_upc UA_MDIV_LP = 5'd23;
    localparam t_upc UA_CLEN    = 5'd24;
    localparam t_upc UA_EMIT    = 5'd25;

    function automatic t_uword uw(input t_act act, input logic emit, input t_status st,
                                  input t_cond cond, input t_upc tgt);
        t_uword w;
        w.act    = act;
        w.emit   = emit;
        w.status = st;
        w.cond   = cond;
        w.target = tgt;
        return w;
    endfunction

    // Control store
    function automatic t_uword ucode(input t_upc a);
        t_uword w;
        unique case (a)
            UA_FETCH:    w = uw(A_NOP,        1'b0, ST_NONE,   C_NO_IN,       UA_FETCH);
            UA_DISP_S:   w = uw(A_NOP,        1'b0, ST_NONE,   C_OP_START,    UA_START);
            UA_DISP_T:   w = uw(A_NOP,        1'b0, ST_NONE,   C_OP_TICK,     UA_TICK);
            UA_DISP_A:   w = uw(A_NOP,        1'b0, ST_NONE,   C_OP_ACK,      UA_ACK);
            UA_NOTHING:  w = uw(A_NOP,        1'b1, ST_NONE,   C_ALWAYS,      UA_FETCH);
            UA_START:    w = uw(A_NOP,        1'b0, ST_NONE,   C_START_BAD,   UA_REJECT);
            UA_LOAD:     w = uw(A_LOAD_START, 1'b0, ST_NONE,   C_ALWAYS,      UA_ISSUE);
            UA_REJECT:   w = uw(A_NOP,        1'b1, ST_REJECT, C_ALWAYS,      UA_FETCH);
            UA_TICK:     w = uw(A_NOP,        1'b0, ST_NONE,   C_TICK_IGNORE, UA_NOTHING);
            UA_TICK_W:   w = uw(A_NOP,        1'b0, ST_NONE,   C_WAIT_GT1,    UA_TICK_DEC);
            UA_TICK_GO:  w = uw(A_NOP,        1'b0, ST_NONE,   C_ALWAYS,      UA_ISSUE);
            UA_TICK_DEC: w = uw(A_DEC_WAIT,   1'b1, ST_NONE,   C_ALWAYS,      UA_FETCH);
            UA_ACK:      w = uw(A_NOP,        1'b0, ST_NONE,   C_ACK_IGNORE,  UA_NOTHING);
            UA_ACK_CHK:  w = uw(A_CLR_AWAIT,  1'b0, ST_NONE,   C_ACK_FAIL,    UA_FAIL);
            UA_ADVANCE:  w = uw(A_ADVANCE,    1'b0, ST_NONE,   C_NEVER,       UA_FETCH);
            UA_REM_CHK:  w = uw(A_NOP,        1'b0, ST_NONE,   C_REM_ZERO,    UA_DONE);
            UA_SPC_CHK:  w = uw(A_NOP,        1'b0, ST_NONE,   C_UNSPACED,    UA_ISSUE);
            UA_TDIV:     w = uw(A_TDIV_INIT,  1'b0, ST_NONE,   C_NEVER,       UA_FETCH);
            UA_TDIV_LP:  w = uw(A_DIV_STEP,   1'b0, ST_NONE,   C_DIV_MORE,    UA_TDIV_LP);
            UA_SET_W:    w = uw(A_SET_WAIT,   1'b1, ST_NONE,   C_ALWAYS,      UA_FETCH);
            UA_FAIL:     w = uw(A_GO_IDLE,    1'b1, ST_FAILED, C_ALWAYS,      UA_FETCH);
            UA_DONE:     w = uw(A_GO_IDLE,    1'b1, ST_DONE,   C_ALWAYS,      UA_FETCH);
            UA_ISSUE:    w = uw(A_MDIV_INIT,  1'b0, ST_NONE,   C_NEVER,       UA_FETCH);
            UA_MDIV_LP:  w = uw(A_DIV_STEP,   1'b0, ST_NONE,   C_DIV_MORE,    UA_MDIV_LP);
            UA_CLEN:     w = uw(A_CLEN,       1'b0, ST_NONE,   C_NEVER,       UA_FETCH);
            UA_EMIT:     w = uw(A_ISSUE,      1'b1, ST_CHUNK,  C_ALWAYS,      UA_FETCH);
            default:     w = uw(A_NOP,        1'b0, ST_NONE,   C_ALWAYS,      UA_FETCH);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/ept_in_if.sv */
// Request channel of the page transfer sequencer: valid/ready plus one request word.
// Depends on ept_pkg for field widths.
`default_nettype none

interface ept_in_if;
    import ept_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic                is_write;
    logic [POS_IN_W-1:0] start_position;
    logic [COUNT_W-1:0]  byte_count;
    logic [SECTOR_W-1:0] sector_bytes;
    logic                chunk_ok;

    modport source (output valid, operation, is_write, start_position, byte_count,
                    sector_bytes, chunk_ok, input ready);
    modport sink   (input valid, operation, is_write, start_position, byte_count,
                    sector_bytes, chunk_ok, output ready);
endinterface

`default_nettype wire

/* rtl/ept_out_if.sv */
// Result channel of the page transfer sequencer: valid/ready plus one result word.
// Depends on ept_pkg for field widths.
`default_nettype none

interface ept_out_if;
    import ept_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                chunk_write;
    logic [BUS_W-1:0]    bus_address;
    logic [IADDR_W-1:0]  internal_address;
    logic [LEN_W-1:0]    chunk_length;

    modport source (output valid, status, chunk_write, bus_address, internal_address,
                    chunk_length, input ready);
    modport sink   (input valid, status, chunk_write, bus_address, internal_address,
                    chunk_length, output ready);
endinterface

`default_nettype wire

/* rtl/ept_cfg_if.sv */
// Configuration write channel: valid/ready, register index and write data.
// Depends on ept_pkg for field widths.
`default_nettype none

interface ept_cfg_if;
    import ept_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/eeprom_page_transfer_sequencer_top.sv */
// Top level of the serial memory page transfer sequencer: microcoded control and datapath.
// Depends on ept_pkg and the ept_in_if, ept_out_if and ept_cfg_if channel interfaces.
`default_nettype none

// Splits a memory transfer into chunks that never cross a sector boundary and
// issues them one by one to an external bus engine. Each request word (start,
// tick or chunk acknowledgement) gives exactly one result word. The block works
// on one request at a time: a short microprogram steps through a control store,
// one control word per clock unless a result step stalls, driving a small
// datapath with a shared one-bit-per-cycle restoring divider (DIV_W =
// max(POSITION_BITS, 18) steps). The divider produces the position modulo
// sector size when a chunk is issued, and the rounded-up write-cycle wait in
// ticks after a write acknowledgement. A result step holds while the previous
// result word is still waiting to be taken. A further request is taken as soon
// as the microprogram returns to fetch, even while the last result still waits
// in the output register. Configuration writes are always taken (ready held
// high) and must only be made while no request is in progress. Unknown
// register indexes are ignored.
module eeprom_page_transfer_sequencer_top #(
    parameter int POSITION_BITS = 19
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    ept_in_if.sink   i_in,
    ept_out_if.source o_out,
    ept_cfg_if.sink  i_cfg
);
    import ept_pkg::*;

    localparam int DIV_W = (POSITION_BITS > WAIT_US_W) ? POSITION_BITS : WAIT_US_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // ---------------- configuration registers ----------------
    logic [BUS_W-1:0]    r_cfg_dev;
    logic [IAB_W-1:0]    r_cfg_iab;
    logic [MS_W-1:0]     r_cfg_ms;
    logic [PERIOD_W-1:0] r_cfg_period;
    logic                r_cfg_spaced;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dev    <= DEV_ADDR_RST;
            r_cfg_iab    <= IAB_RST;
            r_cfg_ms     <= MS_RST;
            r_cfg_period <= PERIOD_RST;
            r_cfg_spaced <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEV_ADDR: r_cfg_dev    <= i_cfg.data[BUS_W-1:0];
                CFG_IAB:      r_cfg_iab    <= i_cfg.data[IAB_W-1:0];
                CFG_DELAY_MS: r_cfg_ms     <= i_cfg.data[MS_W-1:0];
                CFG_TICK_US:  r_cfg_period <= i_cfg.data[PERIOD_W-1:0];
                CFG_SPACED:   r_cfg_spaced <= i_cfg.data[0];
                default: ;    // index outside the register list
            endcase
        end
    end

    // ---------------- sequencer ----------------
    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uw;
    logic   w_cond;
    logic   w_stall;
    logic   w_take;

    // request word latched at fetch
    logic [OP_W-1:0]     r_in_op;
    logic                r_in_wr;
    logic [POS_IN_W-1:0] r_in_pos;
    logic [COUNT_W-1:0]  r_in_cnt;
    logic [SECTOR_W-1:0] r_in_sec;
    logic                r_in_ok;

    // transfer state
    logic                     r_busy;
    logic                     r_dir;
    logic [POSITION_BITS-1:0] r_pos;
    logic [COUNT_W-1:0]       r_remain;
    logic [SECTOR_W-1:0]      r_sec;
    logic [WAIT_W-1:0]        r_wait;
    logic                     r_await;
    logic [LEN_W-1:0]         r_clen;

    // shared restoring divider
    logic [DIV_W-1:0]    r_dvd;     // dividend, becomes quotient
    logic [SECTOR_W-1:0] r_rmd;     // partial remainder
    logic [SECTOR_W-1:0] r_dvs;
    logic [DCNT_W-1:0]   r_dcnt;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_write;
    logic [BUS_W-1:0]    r_o_bus;
    logic [IADDR_W-1:0]  r_o_iaddr;
    logic [LEN_W-1:0]    r_o_len;

    assign w_uw    = ucode(r_upc);
    assign w_stall = w_uw.emit && r_out_valid && !o_out.ready;
    assign i_in.ready = (r_upc == UA_FETCH);
    assign w_take  = i_in.valid && i_in.ready;

    always_comb begin
        unique case (w_uw.cond)
            C_NEVER:       w_cond = 1'b0;
            C_ALWAYS:      w_cond = 1'b1;
            C_NO_IN:       w_cond = !i_in.valid;
            C_OP_START:    w_cond = (r_in_op == OP_START);
            C_OP_TICK:     w_cond = (r_in_op == OP_TICK);
            C_OP_ACK:      w_cond = (r_in_op == OP_ACK);
            C_START_BAD:   w_cond = r_busy || (r_in_cnt == '0) || (r_in_sec == '0);
            C_TICK_IGNORE: w_cond = !r_busy || r_await;
            C_WAIT_GT1:    w_cond = (r_wait > WAIT_W'(1));
            C_ACK_IGNORE:  w_cond = !r_busy || !r_await;
            C_ACK_FAIL:    w_cond = !r_in_ok;
            C_REM_ZERO:    w_cond = (r_remain == '0);
            C_UNSPACED:    w_cond = !r_cfg_spaced;
            C_DIV_MORE:    w_cond = (r_dcnt != DCNT_W'(1));
            default:       w_cond = 1'b0;
        endcase
    end

    always_comb begin
        if (w_stall) begin
            n_upc = r_upc;
        end else if (w_cond) begin
            n_upc = w_uw.target;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_op  <= i_in.operation;
            r_in_wr  <= i_in.is_write;
            r_in_pos <= i_in.start_position;
            r_in_cnt <= i_in.byte_count;
            r_in_sec <= i_in.sector_bytes;
            r_in_ok  <= i_in.chunk_ok;
        end
    end

    // ---------------- datapath ----------------
    logic [SECTOR_W:0]      w_trial;
    logic [SECTOR_W:0]      w_diff;
    logic                   w_ge;
    logic [SECTOR_W-1:0]    w_sec_left;
    logic [LEN_W-1:0]       w_clen;
    logic [WAIT_US_W-1:0]   w_wait_us;
    logic [PERIOD_W-1:0]    w_period;
    logic [POS_EXT_W-1:0]   w_pos_ext;
    logic [BUS_W-1:0]       w_bus;
    logic [IADDR_W-1:0]     w_iaddr;

    assign w_trial = {r_rmd, r_dvd[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // bytes to the end of the sector, capped by what is left
    assign w_sec_left = r_sec - r_rmd;
    assign w_clen = ({{(COUNT_W-SECTOR_W){1'b0}}, w_sec_left} > r_remain)
                    ? r_remain[LEN_W-1:0] : w_sec_left;

    assign w_wait_us = WAIT_US_W'(r_cfg_ms) * US_PER_MS;
    assign w_period  = (r_cfg_period == '0) ? PERIOD_W'(1) : r_cfg_period;

    // split of the position between bus address and internal address
    assign w_pos_ext = POS_EXT_W'(r_pos);
    always_comb begin
        if (r_cfg_iab == IAB_ONE) begin
            w_bus   = r_cfg_dev | w_pos_ext[14:8];
            w_iaddr = {8'h00, w_pos_ext[7:0]};
        end else begin
            w_bus   = r_cfg_dev | w_pos_ext[22:16];
            w_iaddr = w_pos_ext[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_await <= 1'b0;
            r_wait  <= '0;
        end else if (!w_stall) begin
            unique case (w_uw.act)
                A_LOAD_START: r_busy  <= 1'b1;
                A_DEC_WAIT:   r_wait  <= r_wait - WAIT_W'(1);
                A_CLR_AWAIT:  r_await <= 1'b0;
                A_SET_WAIT: begin
                    if (!r_dir || (r_cfg_ms == '0)) begin
                        r_wait <= WAIT_W'(1);
                    end else begin
                        r_wait <= WAIT_W'(r_dvd) + WAIT_W'(r_rmd != '0);
                    end
                end
                A_GO_IDLE: begin
                    r_busy <= 1'b0;
                    r_wait <= '0;
                end
                A_ISSUE: begin
                    r_await <= 1'b1;
                    r_wait  <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            unique case (w_uw.act)
                A_LOAD_START: begin
                    r_dir    <= r_in_wr;
                    r_pos    <= POSITION_BITS'(r_in_pos);
                    r_remain <= r_in_cnt;
                    r_sec    <= r_in_sec;
                end
                A_ADVANCE: begin
                    r_pos    <= r_pos + POSITION_BITS'(r_clen);
                    r_remain <= r_remain - COUNT_W'(r_clen);
                end
                A_TDIV_INIT: begin
                    r_dvd  <= (r_dir) ? DIV_W'(w_wait_us) : '0;
                    r_rmd  <= '0;
                    r_dvs  <= w_period;
                    r_dcnt <= DCNT_W'(DIV_W);
                end
                A_MDIV_INIT: begin
                    r_dvd  <= DIV_W'(r_pos);
                    r_rmd  <= '0;
                    r_dvs  <= r_sec;
                    r_dcnt <= DCNT_W'(DIV_W);
                end
                A_DIV_STEP: begin
                    r_dvd  <= {r_dvd[DIV_W-2:0], w_ge};
                    r_rmd  <= w_ge ? w_diff[SECTOR_W-1:0] : w_trial[SECTOR_W-1:0];
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                end
                A_CLEN: r_clen <= w_clen;
                default: ;
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.emit && !w_stall) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.emit && !w_stall) begin
            r_o_status <= w_uw.status;
            if (w_uw.status == ST_CHUNK) begin
                r_o_write <= r_dir;
                r_o_bus   <= w_bus;
                r_o_iaddr <= w_iaddr;
                r_o_len   <= r_clen;
            end else begin
                r_o_write <= 1'b0;
                r_o_bus   <= '0;
                r_o_iaddr <= '0;
                r_o_len   <= '0;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_o_status;
    assign o_out.chunk_write      = r_o_write;
    assign o_out.bus_address      = r_o_bus;
    assign o_out.internal_address = r_o_iaddr;
    assign o_out.chunk_length     = r_o_len;

endmodule

`default_nettype wire

/* bench/eeprom_page_transfer_sequencer_top_test.sv */
// Self-checking bench for eeprom_page_transfer_sequencer_top: directed table, then random
// transfer traffic over several register settings, each result checked by table or predictor.
// Depends on ept_pkg and the ept_in_if, ept_out_if and ept_cfg_if channel interfaces.
module eeprom_page_transfer_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ept_pkg::*;

    // Operation code the block does not know; it must answer with status none
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic TYPED   = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam int unsigned COUNT_TOP = 524288;
    localparam int unsigned PHASE_WORDS = 66;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                wr;
        logic [POS_IN_W-1:0] pos;
        logic [COUNT_W-1:0]  cnt;
        logic [SECTOR_W-1:0] sec;
        logic                ok;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                wr;
        logic [BUS_W-1:0]    bus;
        logic [IADDR_W-1:0]  ia;
        logic [LEN_W-1:0]    len;
    } t_result;

    typedef struct packed {
        t_request rq;
        logic     typed;
        t_result  res;
    } t_row;

    typedef struct packed {
        logic [BUS_W-1:0]    dev;
        logic [IAB_W-1:0]    iab;
        logic [MS_W-1:0]     delay;
        logic [PERIOD_W-1:0] period;
        logic                spaced;
    } t_setting;

    localparam t_result R_NONE = '{ST_NONE,   1'b0, 7'd0, 16'd0, 16'd0};
    localparam t_result R_REJ  = '{ST_REJECT, 1'b0, 7'd0, 16'd0, 16'd0};
    localparam t_result R_DONE = '{ST_DONE,   1'b0, 7'd0, 16'd0, 16'd0};
    localparam t_result R_FAIL = '{ST_FAILED, 1'b0, 7'd0, 16'd0, 16'd0};

    // Directed part, run with the reset register values (dev 80, two address bytes,
    // 5 ms write cycle, 1000 us tick, spaced): 5 ticks of wait after a write chunk.
    localparam t_row DIRECTED [23] = '{
        // stray words while idle, with unused fields at their largest values or zero
        '{'{OP_ACK,    1'b1, 19'h7FFFF, 20'h80000, 16'hFFFF, 1'b1}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_UNUSED, 1'b1, 19'h7FFFF, 20'h80000, 16'hFFFF, 1'b1}, TYPED, R_NONE},
        // zero count, zero sector
        '{'{OP_START,  1'b1, 19'h00000, 20'h00000, 16'h0010, 1'b0}, TYPED, R_REJ},
        '{'{OP_START,  1'b1, 19'h00000, 20'h00010, 16'h0000, 1'b0}, TYPED, R_REJ},
        // 20 byte write, 16 byte sectors: 16 then 4
        '{'{OP_START,  1'b1, 19'h00000, 20'h00014, 16'h0010, 1'b0}, TYPED,
          '{ST_CHUNK, 1'b1, 7'd80, 16'd0, 16'd16}},
        '{'{OP_START,  1'b0, 19'h00005, 20'h00005, 16'h0005, 1'b0}, TYPED, R_REJ},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_ACK,    1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b1}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, TYPED,
          '{ST_CHUNK, 1'b1, 7'd80, 16'd16, 16'd4}},
        '{'{OP_ACK,    1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b1}, TYPED, R_DONE},
        // top position, largest count and sector, then a failed chunk
        '{'{OP_START,  1'b0, 19'h7FFFF, 20'h80000, 16'hFFFF, 1'b1}, PREDICT, R_NONE},
        '{'{OP_ACK,    1'b1, 19'h7FFFF, 20'h80000, 16'hFFFF, 1'b0}, TYPED, R_FAIL},
        // single byte, single byte sector
        '{'{OP_START,  1'b1, 19'h12345, 20'h00001, 16'h0001, 1'b0}, PREDICT, R_NONE},
        '{'{OP_ACK,    1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b1}, TYPED, R_DONE},
        // read running off the top of the memory: position wraps to zero
        '{'{OP_START,  1'b0, 19'h7FFF0, 20'h00020, 16'h0100, 1'b0}, PREDICT, R_NONE},
        '{'{OP_ACK,    1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b1}, TYPED, R_NONE},
        '{'{OP_TICK,   1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b0}, PREDICT, R_NONE},
        '{'{OP_ACK,    1'b0, 19'h00000, 20'h00000, 16'h0000, 1'b1}, TYPED, R_DONE}
    };

    // Register settings of the random phases, extremes first
    localparam t_setting PHASE_SETTINGS [6] = '{
        '{7'd0,   2'd1, 8'd0,   16'd1,     1'b1},
        '{7'd127, 2'd2, 8'd255, 16'd65535, 1'b1},
        '{7'h2A,  2'd0, 8'd3,   16'd1000,  1'b0},   // unknown width: two bytes
        '{7'h55,  2'd3, 8'd1,   16'd333,   1'b1},   // 1 ms over 333 us ticks rounds up to 4
        '{7'd80,  2'd1, 8'd10,  16'd700,   1'b1},
        '{7'd127, 2'd1, 8'd0,   16'd1,     1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ept_in_if  u_in ();
    ept_out_if u_out ();
    ept_cfg_if u_cfg ();

    eeprom_page_transfer_sequencer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out),
        .i_cfg   (u_cfg)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted registers and transfer state
    logic [BUS_W-1:0]    cfg_dev;
    logic [IAB_W-1:0]    cfg_iab;
    logic [MS_W-1:0]     cfg_delay;
    logic [PERIOD_W-1:0] cfg_period;
    logic                cfg_spaced;

    logic                p_busy;
    logic                p_dirw;
    logic [POS_IN_W-1:0] p_pos;
    logic [COUNT_W-1:0]  p_remain;
    logic [SECTOR_W-1:0] p_sector;
    logic [WAIT_W-1:0]   p_wait;
    logic                p_await;

    t_result pending_results[$];
    int unsigned mismatches = 0;
    logic send_calm = 1'b0;
    logic take_calm = 1'b0;

    // Bytes up to the end of the current sector, capped by what is left
    function automatic int unsigned chunk_bytes();
        int unsigned n;
        n = p_sector - (p_pos % p_sector);
        if (n > p_remain) n = p_remain;
        return n;
    endfunction

    function automatic t_result next_chunk();
        t_result r;
        r.status = ST_CHUNK;
        r.wr     = p_dirw;
        if (cfg_iab == IAB_ONE) begin
            r.bus = cfg_dev | BUS_W'(p_pos >> 8);
            r.ia  = {8'd0, p_pos[7:0]};
        end else begin
            r.bus = cfg_dev | BUS_W'(p_pos >> 16);
            r.ia  = p_pos[15:0];
        end
        r.len   = LEN_W'(chunk_bytes());
        p_await = 1'b1;
        p_wait  = '0;
        return r;
    endfunction

    // One request word in, one expected result word out; advances the predicted state
    function automatic t_result predict_transfer_step(t_request rq);
        t_result r;
        int unsigned n;
        int unsigned per;
        int unsigned us;
        r = R_NONE;
        case (rq.op)
            OP_START: begin
                if (p_busy || rq.cnt == 0 || rq.sec == 0) begin
                    r = R_REJ;
                end else begin
                    p_busy   = 1'b1;
                    p_dirw   = rq.wr;
                    p_pos    = rq.pos;
                    p_remain = rq.cnt;
                    p_sector = rq.sec;
                    r = next_chunk();
                end
            end
            OP_TICK: begin
                if (p_busy && !p_await) begin
                    if (p_wait > 1) p_wait = p_wait - 1'b1;
                    else r = next_chunk();
                end
            end
            OP_ACK: begin
                if (p_busy && p_await) begin
                    p_await = 1'b0;
                    if (!rq.ok) begin
                        p_busy = 1'b0;
                        p_wait = '0;
                        r = R_FAIL;
                    end else begin
                        n = chunk_bytes();
                        p_pos    = p_pos + POS_IN_W'(n);
                        p_remain = p_remain - COUNT_W'(n);
                        if (p_remain == 0) begin
                            p_busy = 1'b0;
                            p_wait = '0;
                            r = R_DONE;
                        end else if (cfg_spaced) begin
                            // write cycle rounded up to whole ticks; one tick after a read
                            per = (cfg_period != 0) ? cfg_period : 1;
                            us  = p_dirw ? cfg_delay * 1000 : 0;
                            p_wait = (us == 0) ? 1 : WAIT_W'((us + per - 1) / per);
                        end else begin
                            r = next_chunk();
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void apply_register(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
        case (idx)
            CFG_DEV_ADDR: cfg_dev    = d[BUS_W-1:0];
            CFG_IAB:      cfg_iab    = d[IAB_W-1:0];
            CFG_DELAY_MS: cfg_delay  = d[MS_W-1:0];
            CFG_TICK_US:  cfg_period = d[PERIOD_W-1:0];
            CFG_SPACED:   cfg_spaced = d[0];
            default: ;
        endcase
    endfunction

    // Idle cycles before a word; long calm stretches switch idling off altogether
    function automatic int unsigned pause_len(logic calm);
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int unsigned the_bit();
        return $urandom_range(0, 1);
    endfunction

    // Drives one request word from a falling edge; returns at the falling edge after it is taken
    task automatic put_request(input t_request rq, input logic typed, input t_result typed_res);
        t_result want;
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        gap = pause_len(send_calm);
        if (gap != 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        u_in.operation      <= rq.op;
        u_in.is_write       <= rq.wr;
        u_in.start_position <= rq.pos;
        u_in.byte_count     <= rq.cnt;
        u_in.sector_bytes   <= rq.sec;
        u_in.chunk_ok       <= rq.ok;
        u_in.valid          <= 1'b1;
        do @(posedge i_clk); while (u_in.ready !== 1'b1);
        want = predict_transfer_step(rq);
        if (typed) want = typed_res;
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    // Holds the request channel quiet until every expected word is back
    task automatic settle();
        u_in.valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic program_registers(input t_setting s);
        t_cfg_idx idx [5];
        logic [CFG_DAT_W-1:0] dat [5];
        idx[0] = CFG_DEV_ADDR;  dat[0] = CFG_DAT_W'(s.dev);
        idx[1] = CFG_IAB;       dat[1] = CFG_DAT_W'(s.iab);
        idx[2] = CFG_DELAY_MS;  dat[2] = CFG_DAT_W'(s.delay);
        idx[3] = CFG_TICK_US;   dat[3] = s.period;
        idx[4] = CFG_SPACED;    dat[4] = CFG_DAT_W'(s.spaced);
        for (int k = 0; k < 5; k++) begin
            u_cfg.index <= idx[k];
            u_cfg.data  <= dat[k];
            u_cfg.valid <= 1'b1;
            do @(posedge i_clk); while (u_cfg.ready !== 1'b1);
            apply_register(idx[k], dat[k]);
            @(negedge i_clk);
        end
        u_cfg.valid <= 1'b0;
    endtask

    // Next random request word, shaped by the predicted state so that most traffic
    // follows a real transfer: start, acknowledge each chunk, tick out each wait.
    // Winding down aborts the running transfer so that the block ends idle.
    task automatic choose_request(input logic wind_down, output t_request rq);
        int unsigned pick;
        int unsigned lim;
        rq.op  = OP_UNUSED;
        rq.wr  = 1'(the_bit());
        rq.pos = POS_IN_W'($urandom);
        rq.cnt = COUNT_W'($urandom_range(0, COUNT_TOP));
        rq.sec = SECTOR_W'($urandom);
        rq.ok  = 1'(the_bit());
        pick = $urandom_range(0, 99);
        if (!p_busy) begin
            if (pick < 4) rq.op = OP_TICK;
            else if (pick < 8) rq.op = OP_ACK;
            else if (pick < 10) rq.op = OP_UNUSED;
            else begin
                rq.op = OP_START;
                if (pick < 13) begin
                    rq.cnt = '0;
                end else if (pick < 16) begin
                    rq.sec = '0;
                end else if (pick < 26) begin
                    // big sectors with any count up to the whole memory
                    rq.sec = SECTOR_W'($urandom_range(16384, 65535));
                    rq.cnt = COUNT_W'($urandom_range(1, COUNT_TOP));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60) rq.sec = SECTOR_W'($urandom_range(1, 64));
                    else if (pick < 85) rq.sec = SECTOR_W'($urandom_range(1, 4096));
                    else rq.sec = SECTOR_W'($urandom_range(1, 65535));
                    lim = rq.sec * 4;
                    if (lim > COUNT_TOP) lim = COUNT_TOP;
                    rq.cnt = COUNT_W'($urandom_range(1, lim));
                end
            end
        end else if (p_await) begin
            if (wind_down) begin
                rq.op = OP_ACK;
                rq.ok = 1'b0;
            end else if (pick < 3) rq.op = OP_START;
            else if (pick < 5) rq.op = OP_TICK;
            else if (pick < 6) rq.op = OP_UNUSED;
            else begin
                rq.op = OP_ACK;
                rq.ok = (pick >= 10);
            end
        end else begin
            if (!wind_down && pick < 3) rq.op = OP_START;
            else if (!wind_down && pick < 6) rq.op = OP_ACK;
            else if (!wind_down && pick < 7) rq.op = OP_UNUSED;
            else rq.op = OP_TICK;
        end
    endtask

    // Result side: random back-pressure, every taken word checked against the oldest expectation
    initial begin
        int unsigned stall;
        t_result want;
        u_out.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            stall = pause_len(take_calm);
            if (stall != 0) begin
                u_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            u_out.ready <= 1'b1;
            do @(posedge i_clk); while (u_out.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting, status %0d", u_out.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status",           want.status, u_out.status);
                compare_field("chunk_write",      want.wr,     u_out.chunk_write);
                compare_field("bus_address",      want.bus,    u_out.bus_address);
                compare_field("internal_address", want.ia,     u_out.internal_address);
                compare_field("chunk_length",     want.len,    u_out.chunk_length);
            end
            @(negedge i_clk);
        end
    end

    // Stimulus: reset, directed table, then one random phase per register setting
    initial begin
        t_request rq;
        u_in.valid          <= 1'b0;
        u_in.operation      <= OP_START;
        u_in.is_write       <= 1'b0;
        u_in.start_position <= '0;
        u_in.byte_count     <= '0;
        u_in.sector_bytes   <= '0;
        u_in.chunk_ok       <= 1'b0;
        u_cfg.valid         <= 1'b0;
        u_cfg.index         <= CFG_DEV_ADDR;
        u_cfg.data          <= '0;
        i_rst_n             <= 1'b0;

        cfg_dev    = DEV_ADDR_RST;
        cfg_iab    = IAB_RST;
        cfg_delay  = MS_RST;
        cfg_period = PERIOD_RST;
        cfg_spaced = 1'b1;
        p_busy     = 1'b0;
        p_dirw     = 1'b0;
        p_pos      = '0;
        p_remain   = '0;
        p_sector   = '0;
        p_wait     = '0;
        p_await    = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[k]) put_request(DIRECTED[k].rq, DIRECTED[k].typed, DIRECTED[k].res);

        foreach (PHASE_SETTINGS[ph]) begin
            // registers change only with the block idle and its last word back
            settle();
            repeat (40) @(negedge i_clk);
            program_registers(PHASE_SETTINGS[ph]);
            for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 49) == 0) settle();
                choose_request(1'b0, rq);
                put_request(rq, PREDICT, R_NONE);
            end
            while (p_busy) begin
                choose_request(1'b1, rq);
                put_request(rq, PREDICT, R_NONE);
            end
        end

        settle();
        repeat (60) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Safety net: far beyond the slowest correct run, long tick waits included
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
